// File: rtl/core/nst_pkg.sv
// ----------------------------------------------------------------------------
// nst_pkg
// Shared types and constants of the script tokenizer: token codes, character
// codes, scan modes and the queue push control.
// ----------------------------------------------------------------------------
package nst_pkg;

   localparam int KIND_BITS = 4;
   localparam int ATTR_BITS = 3;
   localparam int CODE_BITS = 2;
   localparam int HEAD_BITS = KIND_BITS + ATTR_BITS + CODE_BITS;

   // token queue depth and pointer width
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;
   localparam int QCNT_BITS   = 3;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_DOT      = 4'd0,
      KIND_COMMA    = 4'd1,
      KIND_LBRACE   = 4'd2,
      KIND_RBRACE   = 4'd3,
      KIND_LPAREN   = 4'd4,
      KIND_RPAREN   = 4'd5,
      KIND_LBRACKET = 4'd6,
      KIND_RBRACKET = 4'd7,
      KIND_STRING   = 4'd8,
      KIND_ASSIGN   = 4'd9,
      KIND_NUMBER   = 4'd10,
      KIND_IDENT    = 4'd11,
      KIND_EOF      = 4'd12,
      KIND_ERROR    = 4'd13
   } kind_type;

   typedef enum logic [ATTR_BITS-1:0] {
      ATTR_DEFAULT  = 3'd0,
      ATTR_PLAIN_EQ = 3'd1,
      ATTR_PLUS_EQ  = 3'd2,
      ATTR_INTEGER  = 3'd3,
      ATTR_REAL     = 3'd4,
      ATTR_INFINITE = 3'd5
   } attr_type;

   typedef enum logic [CODE_BITS-1:0] {
      ERR_NONE       = 2'd0,
      ERR_UNKNOWN    = 2'd1,
      ERR_STRAY_PLUS = 2'd2,
      ERR_UNCLOSED   = 2'd3
   } err_type;

   // scan modes, one-hot
   typedef enum logic [6:0] {
      MODE_IDLE    = 7'b0000001,
      MODE_COMMENT = 7'b0000010,
      MODE_STRING  = 7'b0000100,
      MODE_PLUS    = 7'b0001000,
      MODE_IDENT   = 7'b0010000,
      MODE_INT     = 7'b0100000,
      MODE_REAL    = 7'b1000000
   } mode_type;

   // character codes
   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_VT     = 8'h0b;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2b;
   localparam logic [7:0] CH_COMMA  = 8'h2c;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_EQ     = 8'h3d;
   localparam logic [7:0] CH_LBRACK = 8'h5b;
   localparam logic [7:0] CH_RBRACK = 8'h5d;
   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;

   // characters of the word "inf"
   function automatic logic [7:0] inf_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0:    ch = 8'h69;
         2'd1:    ch = 8'h6e;
         default: ch = 8'h66;
      endcase
      return ch;
   endfunction

   // tokens written into the queue in one cycle
   typedef struct packed {
      logic push_a;
      logic push_b;
   } push_ctl_type;

endpackage

// File: rtl/core/nst_front.sv
// ----------------------------------------------------------------------------
// nst_front
// Scanner front end: takes one byte a cycle while accept is high, tracks the
// scan mode, line and position, and hands zero, one or two finished tokens to the queue.
// ----------------------------------------------------------------------------
module nst_front import nst_pkg::*; #(
   parameter int POSITION_BITS = 32,
   parameter int LENGTH_BITS   = 16,
   parameter int LINE_BITS     = 24,
   parameter int TOK_BITS      = HEAD_BITS + LINE_BITS + POSITION_BITS + LENGTH_BITS + 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          text_byte,
   input  logic                end_of_text,
   output push_ctl_type        push,
   output logic [TOK_BITS-1:0] tok_a,
   output logic [TOK_BITS-1:0] tok_b
);

   mode_type                 mode_ff, mode_in;
   logic                     at_line_start_ff, at_line_start_in;
   logic [LINE_BITS-1:0]     line_count_ff, line_count_in;
   logic [POSITION_BITS-1:0] byte_pos_ff, byte_pos_in;
   logic [POSITION_BITS-1:0] tok_start_ff, tok_start_in;
   logic [LENGTH_BITS-1:0]   tok_len_ff, tok_len_in;
   logic [1:0]               inf_match_ff, inf_match_in;

   logic                     is_letter, is_digit;
   logic [LENGTH_BITS-1:0]   len_inc;

   // idle scan of the current byte
   logic                     idle_emit;
   kind_type                 idle_kind;
   attr_type                 idle_attr;
   err_type                  idle_code;
   mode_type                 idle_mode;
   logic                     idle_begin;
   logic                     idle_line_start;
   logic                     idle_line_inc;

   // pending token flush
   logic                     flush_v;
   kind_type                 flush_kind;
   attr_type                 flush_attr;
   err_type                  flush_code;
   logic [LENGTH_BITS-1:0]   flush_len;

   // first and second token of this byte
   logic                     f_v, s_v;
   kind_type                 f_kind, s_kind;
   attr_type                 f_attr, s_attr;
   err_type                  f_code, s_code;
   logic [POSITION_BITS-1:0] f_start, s_start;
   logic [LENGTH_BITS-1:0]   f_len, s_len;
   logic                     do_idle;

   assign is_letter = (text_byte inside {[8'h61:8'h7a], [8'h41:8'h5a]});
   assign is_digit  = (text_byte inside {[8'h30:8'h39]});
   assign len_inc   = (tok_len_ff != '1) ? tok_len_ff + 1'b1 : tok_len_ff;

   // byte classification in idle mode
   always_comb begin
      idle_emit       = 1'b0;
      idle_kind       = KIND_ERROR;
      idle_attr       = ATTR_DEFAULT;
      idle_code       = ERR_NONE;
      idle_mode       = MODE_IDLE;
      idle_begin      = 1'b0;
      idle_line_start = (text_byte == CH_NL);
      idle_line_inc   = 1'b0;
      if (at_line_start_ff && text_byte == CH_HASH) begin
         idle_line_start = 1'b0;
         idle_mode       = MODE_COMMENT;
      end else begin
         case (text_byte)
            CH_NL:     idle_line_inc = 1'b1;
            CH_SPACE, CH_TAB, CH_VT: ;
            CH_DOT:    begin idle_emit = 1'b1; idle_kind = KIND_DOT;      end
            CH_COMMA:  begin idle_emit = 1'b1; idle_kind = KIND_COMMA;    end
            CH_LBRACE: begin idle_emit = 1'b1; idle_kind = KIND_LBRACE;   end
            CH_RBRACE: begin idle_emit = 1'b1; idle_kind = KIND_RBRACE;   end
            CH_LPAREN: begin idle_emit = 1'b1; idle_kind = KIND_LPAREN;   end
            CH_RPAREN: begin idle_emit = 1'b1; idle_kind = KIND_RPAREN;   end
            CH_LBRACK: begin idle_emit = 1'b1; idle_kind = KIND_LBRACKET; end
            CH_RBRACK: begin idle_emit = 1'b1; idle_kind = KIND_RBRACKET; end
            CH_EQ: begin
               idle_emit = 1'b1;
               idle_kind = KIND_ASSIGN;
               idle_attr = ATTR_PLAIN_EQ;
            end
            CH_QUOTE: begin idle_begin = 1'b1; idle_mode = MODE_STRING; end
            CH_PLUS:  begin idle_begin = 1'b1; idle_mode = MODE_PLUS;   end
            default: begin
               if (is_letter) begin
                  idle_begin = 1'b1;
                  idle_mode  = MODE_IDENT;
               end else if (is_digit) begin
                  idle_begin = 1'b1;
                  idle_mode  = MODE_INT;
               end else begin
                  idle_emit = 1'b1;
                  idle_kind = KIND_ERROR;
                  idle_code = ERR_UNKNOWN;
               end
            end
         endcase
      end
   end

   // token left pending by the current mode
   always_comb begin
      flush_v    = 1'b1;
      flush_kind = KIND_ERROR;
      flush_attr = ATTR_DEFAULT;
      flush_code = ERR_NONE;
      flush_len  = tok_len_ff;
      case (mode_ff)
         MODE_PLUS: begin
            flush_code = ERR_STRAY_PLUS;
            flush_len  = LENGTH_BITS'(1);
         end
         MODE_STRING: flush_code = ERR_UNCLOSED;
         MODE_IDENT: begin
            if (tok_len_ff == LENGTH_BITS'(3) && inf_match_ff == 2'd3) begin
               flush_kind = KIND_NUMBER;
               flush_attr = ATTR_INFINITE;
            end else begin
               flush_kind = KIND_IDENT;
            end
         end
         MODE_INT: begin
            flush_kind = KIND_NUMBER;
            flush_attr = ATTR_INTEGER;
         end
         MODE_REAL: begin
            flush_kind = KIND_NUMBER;
            flush_attr = ATTR_REAL;
         end
         default: flush_v = 1'b0;
      endcase
   end

   // scanner next state and emitted tokens
   always_comb begin
      mode_in          = mode_ff;
      at_line_start_in = at_line_start_ff;
      line_count_in    = line_count_ff;
      byte_pos_in      = byte_pos_ff;
      tok_start_in     = tok_start_ff;
      tok_len_in       = tok_len_ff;
      inf_match_in     = inf_match_ff;
      do_idle          = 1'b0;
      f_v     = 1'b0;
      f_kind  = flush_kind;
      f_attr  = flush_attr;
      f_code  = flush_code;
      f_start = tok_start_ff;
      f_len   = flush_len;
      s_v     = 1'b0;
      s_kind  = idle_kind;
      s_attr  = idle_attr;
      s_code  = idle_code;
      s_start = byte_pos_ff;
      s_len   = LENGTH_BITS'(1);
      if (accept) begin
         if (end_of_text) begin
            f_v              = flush_v;
            s_v              = 1'b1;
            s_kind           = KIND_EOF;
            s_attr           = ATTR_DEFAULT;
            s_code           = ERR_NONE;
            s_len            = '0;
            mode_in          = MODE_IDLE;
            at_line_start_in = 1'b1;
            line_count_in    = LINE_BITS'(1);
            byte_pos_in      = '0;
            tok_start_in     = '0;
            tok_len_in       = '0;
            inf_match_in     = 2'd0;
         end else begin
            case (mode_ff)
               MODE_STRING: begin
                  tok_len_in = len_inc;
                  if (text_byte == CH_QUOTE) begin
                     f_v     = 1'b1;
                     f_kind  = KIND_STRING;
                     f_attr  = ATTR_DEFAULT;
                     f_code  = ERR_NONE;
                     f_len   = len_inc;
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_COMMENT: do_idle = (text_byte == CH_NL);
               MODE_PLUS: begin
                  if (text_byte == CH_EQ) begin
                     f_v     = 1'b1;
                     f_kind  = KIND_ASSIGN;
                     f_attr  = ATTR_PLUS_EQ;
                     f_code  = ERR_NONE;
                     f_len   = LENGTH_BITS'(2);
                     mode_in = MODE_IDLE;
                  end else begin
                     f_v     = 1'b1;
                     do_idle = 1'b1;
                  end
               end
               MODE_IDENT: begin
                  if (is_letter || is_digit) begin
                     if (tok_len_ff < LENGTH_BITS'(3) && inf_match_ff == tok_len_ff[1:0]
                         && text_byte == inf_char(tok_len_ff[1:0]))
                        inf_match_in = inf_match_ff + 2'd1;
                     tok_len_in = len_inc;
                  end else begin
                     f_v     = 1'b1;
                     do_idle = 1'b1;
                  end
               end
               MODE_INT: begin
                  if (is_digit || text_byte == CH_DOT) begin
                     if (text_byte == CH_DOT)
                        mode_in = MODE_REAL;
                     tok_len_in = len_inc;
                  end else begin
                     f_v     = 1'b1;
                     do_idle = 1'b1;
                  end
               end
               MODE_REAL: begin
                  if (is_digit) begin
                     tok_len_in = len_inc;
                  end else begin
                     f_v     = 1'b1;
                     do_idle = 1'b1;
                  end
               end
               default: do_idle = 1'b1;
            endcase
            // delimiter byte or idle byte goes through the idle scan
            if (do_idle) begin
               s_v              = idle_emit;
               mode_in          = idle_mode;
               at_line_start_in = idle_line_start;
               if (idle_line_inc && line_count_ff != '1)
                  line_count_in = line_count_ff + 1'b1;
               if (idle_begin) begin
                  tok_start_in = byte_pos_ff;
                  tok_len_in   = LENGTH_BITS'(1);
                  if (idle_mode == MODE_IDENT)
                     inf_match_in = (text_byte == inf_char(2'd0)) ? 2'd1 : 2'd0;
               end
            end
            byte_pos_in = byte_pos_ff + 1'b1;
         end
      end
   end

   // compact the two slots into queue words, last flag on the final one
   always_comb begin
      push.push_a = f_v || s_v;
      push.push_b = f_v && s_v;
      if (f_v)
         tok_a = {!s_v, f_len, f_start, line_count_ff, f_code, f_attr, f_kind};
      else
         tok_a = {1'b1, s_len, s_start, line_count_ff, s_code, s_attr, s_kind};
      tok_b = {1'b1, s_len, s_start, line_count_ff, s_code, s_attr, s_kind};
   end

   // scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_IDLE;
         at_line_start_ff <= 1'b1;
         line_count_ff    <= LINE_BITS'(1);
         byte_pos_ff      <= '0;
         tok_start_ff     <= '0;
         tok_len_ff       <= '0;
         inf_match_ff     <= 2'd0;
      end else begin
         mode_ff          <= mode_in;
         at_line_start_ff <= at_line_start_in;
         line_count_ff    <= line_count_in;
         byte_pos_ff      <= byte_pos_in;
         tok_start_ff     <= tok_start_in;
         tok_len_ff       <= tok_len_in;
         inf_match_ff     <= inf_match_in;
      end
   end

endmodule

// File: rtl/core/nst_queue.sv
// ----------------------------------------------------------------------------
// nst_queue
// Token queue between scanner and result port: takes up to two words a
// cycle, delivers one word a cycle from its head while rd_ready is high.
// ----------------------------------------------------------------------------
module nst_queue import nst_pkg::*; #(
   parameter int WIDTH = 82
) (
   input  logic             clock,
   input  logic             reset,
   input  push_ctl_type     push,
   input  logic [WIDTH-1:0] wr_a,
   input  logic [WIDTH-1:0] wr_b,
   output logic             has_space,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0]     slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 pop;

   // room for a two-word burst
   assign has_space = (count_ff <= QCNT_BITS'(QUEUE_DEPTH - 2));
   assign rd_valid  = (count_ff != '0);
   assign rd_data   = slot_ff[rd_ptr_ff];
   assign pop       = rd_valid && rd_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_BITS'(push.push_a) + QPTR_BITS'(push.push_b);
      rd_ptr_in = rd_ptr_ff + QPTR_BITS'(pop);
      count_in  = count_ff + QCNT_BITS'(push.push_a) + QCNT_BITS'(push.push_b)
                  - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (push.push_a)
         slot_ff[wr_ptr_ff] <= wr_a;
      if (push.push_b)
         slot_ff[wr_ptr_ff + 1'b1] <= wr_b;
   end

endmodule

// File: rtl/core/network_script_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// network_script_tokenizer_unit
// Streaming tokenizer for network description scripts: source bytes in,
// classified tokens with line, offset and length out.
// ----------------------------------------------------------------------------
//
//  channel   direction  word contents
//  req_*     in         tdata: text_byte; tlast: end of text
//  rsp_*     out        tdata: kind, attr, error code, line, offset, length;
//                       tlast: final token of an input word
//
//  One byte a cycle is scanned while req_tready is high; a byte that ends one
//  token and forms another, or the end marker after a pending token, gives
//  two tokens, which the result port drains one word a cycle while rsp_tready
//  is high. The four-entry queue takes input while two entries are free.
//  Reset is synchronous and returns the scanner to line 1, offset 0 with an
//  empty queue. A stall on rsp_tready backs up the queue and then req_tready.
//
module network_script_tokenizer_unit import nst_pkg::*; #(
   parameter int POSITION_BITS = 32,
   parameter int LENGTH_BITS   = 16,
   parameter int LINE_BITS     = 24,
   localparam int FIELD_BITS   = HEAD_BITS + LINE_BITS + POSITION_BITS + LENGTH_BITS,
   localparam int DATA_BITS    = ((FIELD_BITS + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // text_byte
   input  logic                 req_tlast,   // end_of_text
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // token_kind, token_attr, error_code, line_number, start_offset, token_length
   output logic [DATA_BITS-1:0] rsp_tdata,
   output logic                 rsp_tlast    // last_of_run
);

   localparam int TOK_BITS = FIELD_BITS + 1;

   push_ctl_type        push;
   logic [TOK_BITS-1:0] tok_a, tok_b, head;
   logic                accept;

   assign accept = req_tvalid && req_tready;

   // scanner
   nst_front #(
      .POSITION_BITS (POSITION_BITS),
      .LENGTH_BITS   (LENGTH_BITS),
      .LINE_BITS     (LINE_BITS),
      .TOK_BITS      (TOK_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .push        (push),
      .tok_a       (tok_a),
      .tok_b       (tok_b)
   );

   // token queue and result port
   nst_queue #(
      .WIDTH (TOK_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_a      (tok_a),
      .wr_b      (tok_b),
      .has_space (req_tready),
      .rd_valid  (rsp_tvalid),
      .rd_ready  (rsp_tready),
      .rd_data   (head)
   );

   assign rsp_tdata = DATA_BITS'(head[FIELD_BITS-1:0]);
   assign rsp_tlast = head[FIELD_BITS];

endmodule

// File: rtl/core/nst_checker.sv
// ----------------------------------------------------------------------------
// nst_checker
// Port-level checks of the tokenizer: result hold under stall, reset state
// and consistency of the token fields.
// ----------------------------------------------------------------------------
module nst_checker import nst_pkg::*; #(
   parameter int POSITION_BITS = 32,
   parameter int LENGTH_BITS   = 16,
   parameter int LINE_BITS     = 24,
   localparam int LEN_LO       = HEAD_BITS + LINE_BITS + POSITION_BITS,
   localparam int DATA_BITS    = ((LEN_LO + LENGTH_BITS + 7) / 8) * 8
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [DATA_BITS-1:0] rsp_tdata,
   input logic                 rsp_tlast
);

   logic [KIND_BITS-1:0]   kind;
   logic [ATTR_BITS-1:0]   attr;
   logic [CODE_BITS-1:0]   code;
   logic [LENGTH_BITS-1:0] len;

   assign kind = rsp_tdata[KIND_BITS-1:0];
   assign attr = rsp_tdata[KIND_BITS+ATTR_BITS-1:KIND_BITS];
   assign code = rsp_tdata[HEAD_BITS-1:KIND_BITS+ATTR_BITS];
   assign len  = rsp_tdata[LEN_LO+LENGTH_BITS-1:LEN_LO];

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed under stall");

   // queue empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // input side open right after reset
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready right after reset");

   // end-of-file closes the run with zero length and default attribute
   a_eof_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind == KIND_EOF |-> rsp_tlast && len == '0 && attr == ATTR_DEFAULT)
      else $error("malformed end-of-file token");

   // error code present exactly on error tokens
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((kind == KIND_ERROR) == (code != ERR_NONE)))
      else $error("error code does not match token kind");

endmodule

bind network_script_tokenizer_unit nst_checker #(
   .POSITION_BITS (POSITION_BITS),
   .LENGTH_BITS   (LENGTH_BITS),
   .LINE_BITS     (LINE_BITS)
) u_nst_checker (.*);

// File: sim/nst_token_checker.sv
// ----------------------------------------------------------------------------
// nst_token_checker
// Watches both streams of the script tokenizer. Every accepted source word
// runs through a local scanner that predicts its tokens. Every returned word
// is matched field by field against the oldest predicted token.
// ----------------------------------------------------------------------------
module nst_token_checker import nst_pkg::*; #(
   parameter int POSITION_BITS = 32,
   parameter int LENGTH_BITS   = 16,
   parameter int LINE_BITS     = 24,
   parameter int DATA_BITS     = 88
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [7:0]           req_tdata,   // text_byte
   input  logic                 req_tlast,   // end_of_text
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // token_kind, token_attr, error_code, line_number, start_offset, token_length
   input  logic [DATA_BITS-1:0] rsp_tdata,
   input  logic                 rsp_tlast,   // last_of_run
   output int                   fail_count,
   output int                   open_count,
   output int                   tokens_seen
);

   localparam int LINE_LSB   = HEAD_BITS;
   localparam int POS_LSB    = LINE_LSB + LINE_BITS;
   localparam int LEN_LSB    = POS_LSB + POSITION_BITS;
   localparam int FIELD_BITS = LEN_LSB + LENGTH_BITS;

   localparam logic [LENGTH_BITS-1:0] LEN_ONE = 1;
   localparam logic [LENGTH_BITS-1:0] LEN_TWO = 2;
   localparam logic [23:0]            INF_TEXT = "inf";

   typedef struct {
      kind_type                 kind;
      attr_type                 attr;
      err_type                  code;
      logic [LINE_BITS-1:0]     line;
      logic [POSITION_BITS-1:0] offset;
      logic [LENGTH_BITS-1:0]   length;
      logic                     last;
   } token_type;

   // scanner state
   mode_type                 scan_mode;
   logic                     at_bol;
   logic [LINE_BITS-1:0]     line_cnt;
   logic [POSITION_BITS-1:0] byte_pos;
   logic [POSITION_BITS-1:0] tok_start;
   logic [LENGTH_BITS-1:0]   tok_len;
   logic [1:0]               inf_hits;

   token_type burst[$];
   token_type tokens_due[$];
   int        errors;
   int        checked;

   initial begin
      errors  = 0;
      checked = 0;
   end

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   task automatic clear_scanner();
      scan_mode = MODE_IDLE;
      at_bol    = 1'b1;
      line_cnt  = LINE_BITS'(1);
      byte_pos  = '0;
      tok_start = '0;
      tok_len   = '0;
      inf_hits  = '0;
   endtask

   task automatic predict_token(input kind_type k, input attr_type a, input err_type e,
                                input logic [POSITION_BITS-1:0] start,
                                input logic [LENGTH_BITS-1:0] len);
      token_type t;
      t.kind   = k;
      t.attr   = a;
      t.code   = e;
      t.line   = line_cnt;
      t.offset = start;
      t.length = len;
      t.last   = 1'b0;
      burst.push_back(t);
   endtask

   task automatic open_token(input mode_type m);
      scan_mode = m;
      tok_start = byte_pos;
      tok_len   = LEN_ONE;
   endtask

   task automatic bump_len();
      if (tok_len != '1) tok_len = tok_len + 1'b1;
   endtask

   // emit whatever token is pending and go idle
   task automatic close_token();
      case (scan_mode)
         MODE_PLUS:   predict_token(KIND_ERROR, ATTR_DEFAULT, ERR_STRAY_PLUS, tok_start,
                                    LEN_ONE);
         MODE_STRING: predict_token(KIND_ERROR, ATTR_DEFAULT, ERR_UNCLOSED, tok_start,
                                    tok_len);
         MODE_IDENT: begin
            if (tok_len == 3 && inf_hits == 2'd3)
               predict_token(KIND_NUMBER, ATTR_INFINITE, ERR_NONE, tok_start, tok_len);
            else
               predict_token(KIND_IDENT, ATTR_DEFAULT, ERR_NONE, tok_start, tok_len);
         end
         MODE_INT:    predict_token(KIND_NUMBER, ATTR_INTEGER, ERR_NONE, tok_start, tok_len);
         MODE_REAL:   predict_token(KIND_NUMBER, ATTR_REAL, ERR_NONE, tok_start, tok_len);
         default: ;
      endcase
      scan_mode = MODE_IDLE;
   endtask

   // a byte seen with nothing pending
   task automatic scan_free(input logic [7:0] c);
      if (at_bol && c == CH_HASH) begin
         at_bol    = 1'b0;
         scan_mode = MODE_COMMENT;
      end else begin
         at_bol = (c == CH_NL);
         case (c)
            CH_NL: if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
            CH_SPACE, CH_TAB, CH_VT: ;
            CH_DOT:    predict_token(KIND_DOT, ATTR_DEFAULT, ERR_NONE, byte_pos, LEN_ONE);
            CH_COMMA:  predict_token(KIND_COMMA, ATTR_DEFAULT, ERR_NONE, byte_pos, LEN_ONE);
            CH_LBRACE: predict_token(KIND_LBRACE, ATTR_DEFAULT, ERR_NONE, byte_pos, LEN_ONE);
            CH_RBRACE: predict_token(KIND_RBRACE, ATTR_DEFAULT, ERR_NONE, byte_pos, LEN_ONE);
            CH_LPAREN: predict_token(KIND_LPAREN, ATTR_DEFAULT, ERR_NONE, byte_pos, LEN_ONE);
            CH_RPAREN: predict_token(KIND_RPAREN, ATTR_DEFAULT, ERR_NONE, byte_pos, LEN_ONE);
            CH_LBRACK: predict_token(KIND_LBRACKET, ATTR_DEFAULT, ERR_NONE, byte_pos, LEN_ONE);
            CH_RBRACK: predict_token(KIND_RBRACKET, ATTR_DEFAULT, ERR_NONE, byte_pos, LEN_ONE);
            CH_EQ:     predict_token(KIND_ASSIGN, ATTR_PLAIN_EQ, ERR_NONE, byte_pos, LEN_ONE);
            CH_QUOTE:  open_token(MODE_STRING);
            CH_PLUS:   open_token(MODE_PLUS);
            default: begin
               if (is_letter(c)) begin
                  open_token(MODE_IDENT);
                  inf_hits = (c == "i") ? 2'd1 : 2'd0;
               end else if (is_digit(c)) begin
                  open_token(MODE_INT);
               end else begin
                  predict_token(KIND_ERROR, ATTR_DEFAULT, ERR_UNKNOWN, byte_pos, LEN_ONE);
               end
            end
         endcase
      end
   endtask

   // predict the tokens of one accepted source word
   task automatic scan_word(input logic [7:0] c, input logic eot);
      burst.delete();
      if (eot) begin
         close_token();
         predict_token(KIND_EOF, ATTR_DEFAULT, ERR_NONE, byte_pos, '0);
         clear_scanner();
      end else begin
         case (scan_mode)
            MODE_STRING: begin
               bump_len();
               if (c == CH_QUOTE) begin
                  predict_token(KIND_STRING, ATTR_DEFAULT, ERR_NONE, tok_start, tok_len);
                  scan_mode = MODE_IDLE;
               end
            end
            MODE_COMMENT: begin
               if (c == CH_NL) begin
                  scan_mode = MODE_IDLE;
                  scan_free(c);
               end
            end
            MODE_PLUS: begin
               if (c == CH_EQ) begin
                  predict_token(KIND_ASSIGN, ATTR_PLUS_EQ, ERR_NONE, tok_start, LEN_TWO);
                  scan_mode = MODE_IDLE;
               end else begin
                  close_token();
                  scan_free(c);
               end
            end
            MODE_IDENT: begin
               if (is_letter(c) || is_digit(c)) begin
                  // track how much of the word inf the name spells so far
                  if (tok_len < 3 && LENGTH_BITS'(inf_hits) == tok_len &&
                      c == INF_TEXT[23 - 8*tok_len[1:0] -: 8])
                     inf_hits = inf_hits + 1'b1;
                  bump_len();
               end else begin
                  close_token();
                  scan_free(c);
               end
            end
            MODE_INT: begin
               if (is_digit(c) || c == CH_DOT) begin
                  if (c == CH_DOT) scan_mode = MODE_REAL;
                  bump_len();
               end else begin
                  close_token();
                  scan_free(c);
               end
            end
            MODE_REAL: begin
               if (is_digit(c)) begin
                  bump_len();
               end else begin
                  close_token();
                  scan_free(c);
               end
            end
            default: begin
               scan_mode = MODE_IDLE;
               scan_free(c);
            end
         endcase
         byte_pos = byte_pos + 1'b1;
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) tokens_due.push_back(burst[i]);
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         errors++;
      end
   endtask

   // compare one returned word with the oldest prediction
   task automatic check_token();
      token_type want;
      checked++;
      if (tokens_due.size() == 0) begin
         $display("%0t: unexpected token word, expected none, got %h", $time, rsp_tdata);
         errors++;
      end else begin
         want = tokens_due.pop_front();
         check_field("kind", want.kind, rsp_tdata[KIND_BITS-1:0]);
         check_field("attr", want.attr, rsp_tdata[KIND_BITS +: ATTR_BITS]);
         check_field("error code", want.code, rsp_tdata[KIND_BITS+ATTR_BITS +: CODE_BITS]);
         check_field("line", want.line, rsp_tdata[LINE_LSB +: LINE_BITS]);
         check_field("offset", want.offset, rsp_tdata[POS_LSB +: POSITION_BITS]);
         check_field("length", want.length, rsp_tdata[LEN_LSB +: LENGTH_BITS]);
         check_field("last", want.last, rsp_tlast);
         check_field("padding", 64'd0, 64'(rsp_tdata >> FIELD_BITS));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_scanner();
         tokens_due.delete();
      end else begin
         if (req_tvalid && req_tready) scan_word(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_token();
      end
      fail_count  <= errors;
      open_count  <= tokens_due.size();
      tokens_seen <= checked;
   end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the script tokenizer testbench. Feeds short directed texts, then
// random scripts built from well-formed lexemes mixed with noise, then one
// long string without gaps, with random gaps on both streams. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb import nst_pkg::*;;

   localparam int POSITION_BITS = 32;
   localparam int LENGTH_BITS   = 16;
   localparam int LINE_BITS     = 24;
   localparam int DATA_BITS     =
      ((HEAD_BITS + LINE_BITS + POSITION_BITS + LENGTH_BITS + 7) / 8) * 8;
   localparam int RANDOM_WORDS  = 1200;
   localparam int LONG_BODY     = 200;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = 8'h00;
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;
   logic                 rsp_tlast;
   logic                 gaps_on    = 1'b1;

   int fail_count;
   int open_count;
   int tokens_seen;
   int words_sent = 0;
   int texts_sent = 0;

   network_script_tokenizer_unit #(
      .POSITION_BITS (POSITION_BITS),
      .LENGTH_BITS   (LENGTH_BITS),
      .LINE_BITS     (LINE_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   nst_token_checker #(
      .POSITION_BITS (POSITION_BITS),
      .LENGTH_BITS   (LENGTH_BITS),
      .LINE_BITS     (LINE_BITS),
      .DATA_BITS     (DATA_BITS)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .open_count  (open_count),
      .tokens_seen (tokens_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #200000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // token sink with random back-pressure
   always @(posedge clock) begin
      rsp_tready <= !gaps_on || ($urandom_range(0, 99) >= 38);
   end

   // one source word, with optional idle cycles ahead of it
   task automatic send_word(input logic [7:0] b, input logic eot);
      while (gaps_on && $urandom_range(0, 99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
   endtask

   // end marker; the data byte is a don't-care
   task automatic end_text();
      send_word(8'($urandom_range(0, 255)), 1'b1);
      texts_sent++;
   endtask

   function automatic logic [7:0] rand_alnum(input logic letters_only);
      int k;
      k = letters_only ? $urandom_range(0, 51) : $urandom_range(0, 61);
      if (k < 26) return 8'("a" + k);
      if (k < 52) return 8'("A" + k - 26);
      return 8'("0" + k - 52);
   endfunction

   task automatic send_comment_line();
      logic [7:0] b;
      send_word(CH_HASH, 1'b0);
      repeat ($urandom_range(0, 6)) begin
         b = 8'($urandom_range(0, 255));
         send_word((b == CH_NL) ? CH_HASH : b, 1'b0);
      end
      send_word(CH_NL, 1'b0);
   endtask

   // one random lexeme, separator or noise byte
   task automatic send_fragment();
      string      punct;
      logic [7:0] b;
      punct = ".,{}()[]";
      case ($urandom_range(0, 11))
         0: send_word(punct[$urandom_range(0, 7)], 1'b0);
         1: begin
            if ($urandom_range(0, 1) == 0)
               send_text("=");
            else
               send_text("+=");
         end
         2: begin
            case ($urandom_range(0, 4))
               0: send_text("inf");
               1: send_text("in");
               2: send_text("inf7");
               default: begin
                  send_word(rand_alnum(1'b1), 1'b0);
                  repeat ($urandom_range(0, 7)) send_word(rand_alnum(1'b0), 1'b0);
               end
            endcase
         end
         3: begin
            repeat ($urandom_range(1, 4)) send_word(8'("0" + $urandom_range(0, 9)), 1'b0);
            if ($urandom_range(0, 1) == 0) begin
               send_word(CH_DOT, 1'b0);
               repeat ($urandom_range(0, 3))
                  send_word(8'("0" + $urandom_range(0, 9)), 1'b0);
            end
         end
         4: begin
            send_word(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 8)) begin
               b = 8'($urandom_range(0, 255));
               send_word((b == CH_QUOTE) ? CH_NL : b, 1'b0);
            end
            if ($urandom_range(0, 7) != 0) send_word(CH_QUOTE, 1'b0);
         end
         5, 6: begin
            case ($urandom_range(0, 2))
               0: send_word(CH_SPACE, 1'b0);
               1: send_word(CH_TAB, 1'b0);
               default: send_word(CH_VT, 1'b0);
            endcase
         end
         7: begin
            send_word(CH_NL, 1'b0);
            if ($urandom_range(0, 2) == 0) send_comment_line();
         end
         8: send_word(8'($urandom_range(0, 255)), 1'b0);
         9: send_word(CH_PLUS, 1'b0);
         default: send_word(CH_SPACE, 1'b0);
      endcase
   endtask

   initial begin
      int         random_start;
      logic [7:0] b;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: comment at start of text, all punctuation, both assigns,
      // stray plus, unknown symbol, newline inside a string, inf, a real
      send_text("#c\n.,{}()[]=+=+!\"a\nb\"inf 9.5");
      end_text();
      // control and high bytes, hash not at line start, unclosed quote
      send_word(8'h00, 1'b0);
      send_word(8'hff, 1'b0);
      send_word(8'h0d, 1'b0);
      send_text("7\t\v#\"q");
      end_text();
      // name cut by a plus that is still pending at the end marker
      send_text("x+");
      end_text();

      // random scripts, with a quiet stretch in the middle
      random_start = words_sent;
      while (words_sent < random_start + RANDOM_WORDS) begin
         gaps_on <= !(words_sent - random_start >= 600 && words_sent - random_start < 900);
         if ($urandom_range(0, 3) == 0) send_comment_line();
         repeat ($urandom_range(1, 40)) send_fragment();
         end_text();
      end

      // one long string sent back to back
      gaps_on <= 1'b0;
      send_word(CH_QUOTE, 1'b0);
      repeat (LONG_BODY) begin
         b = 8'($urandom_range(0, 255));
         send_word((b == CH_QUOTE) ? CH_SPACE : b, 1'b0);
      end
      send_text("\" 1");
      end_text();
      req_tvalid <= 1'b0;

      // drain, then keep watching for anything spurious
      @(posedge clock);
      gaps_on <= 1'b1;
      while (open_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d source words in %0d texts (directed, random and one long string);",
               words_sent, texts_sent);
      $display("checked %0d tokens under random stalls on both streams.", tokens_seen);
      if (fail_count == 0 && open_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
